// ===== rtl/stable_max_priority_queue_unit_defines.svh =====
// Assertion macros shared by the priority queue RTL.
// Needs nothing else; included by modules that carry assertions.
`ifndef STABLE_MAX_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_MAX_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SMPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpq assertion failed");

// Next-cycle implication, checked out of reset.
`define SMPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpq assertion failed");

`endif

// ===== rtl/smpq_pkg.sv =====
// Types and codes for the stable max priority queue.
// No dependencies; used by smpq_cell and the top level.
package smpq_pkg;

    localparam int TAG_W  = 16;
    localparam int PRIO_W = 32;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;
    localparam int CMD_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SERVE  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_SERVED = 2'd0,
        ST_DONE   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic serve;
    } cell_ctrl_t;

endpackage

// ===== rtl/smpq_cell.sv =====
// One position of the sorted chain: holds an entry, shifts toward its
// neighbors. Depends on smpq_pkg.
module smpq_cell
(
    input  logic                clk,
    input  smpq_pkg::cell_ctrl_t ctrl,
    input  smpq_pkg::entry_t    new_ent,
    input  logic                occupied,
    input  logic                left_ge,
    input  smpq_pkg::entry_t    left_ent,
    input  smpq_pkg::entry_t    right_ent,
    output logic                ge,
    output smpq_pkg::entry_t    ent
);

    smpq_pkg::entry_t ent_reg;
    smpq_pkg::entry_t ent_next;

    // held entry ranks ahead of (or ties with) the incoming one
    assign ge  = occupied && (ent_reg.prio >= new_ent.prio);
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.insert)
        begin
            if (ge)
                ent_next = ent_reg;
            else if (left_ge)
                ent_next = new_ent;
            else
                ent_next = left_ent;
        end
        else if (ctrl.serve)
        begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

// ===== rtl/stable_max_priority_queue_unit.sv =====
// Stable max priority queue: a chain of DEPTH cells kept in serve order.
// The result is captured in the output register as the request is accepted.
// Throughput: one request per cycle while the output is drained; every cell makes its own
// compare against the incoming priority, and all cells shift together.
// Reset: entry count and output valid clear; cell contents stay undefined.
`include "stable_max_priority_queue_unit_defines.svh"

module stable_max_priority_queue_unit
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [15:0] item_tag, [47:16] priority_req
    input  logic [1:0]  s_axis_tuser,  // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [15:0] served_tag, [20:16] occupancy_after
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    localparam int CW = $clog2(DEPTH + 1);

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    logic             take;
    logic             out_vld_reg;
    smpq_pkg::entry_t new_ent;

    assign take          = s_axis_tvalid && s_axis_tready;
    // output register frees up in the same cycle it is drained
    assign s_axis_tready = !out_vld_reg || m_axis_tready;
    assign new_ent.tag   = s_axis_tdata[15:0];
    assign new_ent.prio  = $signed(s_axis_tdata[47:16]);

    // ---------------------------------------------------------------
    // Occupancy and command decode
    // ---------------------------------------------------------------
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 full;
    logic                 empty;
    smpq_pkg::cell_ctrl_t ctrl;
    smpq_pkg::status_t    status;
    logic [smpq_pkg::TAG_W-1:0] served_tag;
    smpq_pkg::entry_t     ent [DEPTH];
    logic [DEPTH-1:0]     ge;
    logic [DEPTH-1:0]     occupied;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        status     = smpq_pkg::ST_DONE;
        served_tag = '0;
        if (take)
        begin
            case (s_axis_tuser)
                smpq_pkg::CMD_INSERT:
                begin
                    if (full)
                        status = smpq_pkg::ST_FULL;
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                smpq_pkg::CMD_SERVE:
                begin
                    if (empty)
                        status = smpq_pkg::ST_EMPTY;
                    else
                    begin
                        ctrl.serve = 1'b1;
                        served_tag = ent[0].tag;
                        status     = smpq_pkg::ST_SERVED;
                        count_next = count_reg - 1'b1;
                    end
                end
                smpq_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    // unused code: no operation
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // ---------------------------------------------------------------
    // Cell chain: cell 0 holds the best entry. On insert each cell keeps,
    // takes the new entry, or takes its left neighbor; ties stay ahead,
    // which keeps equal priorities in arrival order. Serve shifts left.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             left_ge;
        smpq_pkg::entry_t left_ent;
        smpq_pkg::entry_t right_ent;

        assign occupied[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_ge  = 1'b1;
            assign left_ent = new_ent;
        end
        else
        begin : g_body
            assign left_ge  = ge[i-1];
            assign left_ent = ent[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_ent = ent[i];
        end
        else
        begin : g_mid
            assign right_ent = ent[i+1];
        end

        smpq_cell u_cell
        (
            .clk       (clk),
            .ctrl      (ctrl),
            .new_ent   (new_ent),
            .occupied  (occupied[i]),
            .left_ge   (left_ge),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .ge        (ge[i]),
            .ent       (ent[i])
        );
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [smpq_pkg::TAG_W-1:0]  out_tag_reg;
    logic [smpq_pkg::STAT_W-1:0] out_stat_reg;
    logic [smpq_pkg::OCC_W-1:0]  out_occ_reg;
    logic [CW+smpq_pkg::OCC_W-1:0] occ_ext;

    // occupancy field is count masked to five bits
    assign occ_ext = {{smpq_pkg::OCC_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (take)
            out_vld_reg <= 1'b1;
        else if (m_axis_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_tag_reg  <= served_tag;
            out_stat_reg <= status;
            out_occ_reg  <= occ_ext[smpq_pkg::OCC_W-1:0];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {3'b000, out_occ_reg, out_tag_reg};
    assign m_axis_tuser  = out_stat_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SMPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `SMPQ_ASSERT_IMP(a_ge_prefix, clk, rst_n, 1'b1, ((ge + 1'b1) & ge) == '0)
    `SMPQ_ASSERT_NXT(a_insert_grows, clk, rst_n, ctrl.insert,
        count_reg == $past(count_reg) + 1'b1)
    `SMPQ_ASSERT_NXT(a_serve_shrinks, clk, rst_n, ctrl.serve,
        count_reg == $past(count_reg) - 1'b1)

endmodule
